[sv/vfce_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vfce_pkg
// Shared types, face codes and lookup functions for the voxel face emitter.
// ----------------------------------------------------------------------------
package vfce_pkg;

    localparam int VERTS_PER_FACE = 6;
    localparam int NUM_FACES      = 6;

    typedef enum logic [2:0] {
        FACE_FRONT  = 3'd0,
        FACE_BACK   = 3'd1,
        FACE_LEFT   = 3'd2,
        FACE_RIGHT  = 3'd3,
        FACE_BOTTOM = 3'd4,
        FACE_TOP    = 3'd5
    } face_t;

    localparam logic [2:0] LAST_VERT = 3'(VERTS_PER_FACE - 1);

    // one queued voxel; faces holds the exposed faces, never zero
    typedef struct packed {
        logic signed [15:0] bx;
        logic signed [15:0] by;
        logic signed [15:0] bz;
        logic [7:0]         r;
        logic [7:0]         g;
        logic [7:0]         b;
        logic [5:0]         faces;
    } voxel_t;

    // corner code: bit0 x offset, bit1 y offset, bit2 z offset
    function automatic logic [2:0] corner_of(input face_t face, input logic [2:0] vert);
        logic [17:0] row;
        logic [2:0]  c;
        begin
            // vertex 0 in the low bits
            unique case (face)
                FACE_FRONT:  row = {3'd6, 3'd7, 3'd4, 3'd7, 3'd5, 3'd4};
                FACE_BACK:   row = {3'd3, 3'd2, 3'd0, 3'd1, 3'd3, 3'd0};
                FACE_LEFT:   row = {3'd0, 3'd2, 3'd4, 3'd2, 3'd6, 3'd4};
                FACE_RIGHT:  row = {3'd3, 3'd1, 3'd5, 3'd7, 3'd3, 3'd5};
                FACE_BOTTOM: row = {3'd4, 3'd5, 3'd0, 3'd5, 3'd1, 3'd0};
                FACE_TOP:    row = {3'd7, 3'd6, 3'd2, 3'd3, 3'd7, 3'd2};
                default:     row = '0;
            endcase
            case (vert)
                3'd0:    c = row[2:0];
                3'd1:    c = row[5:3];
                3'd2:    c = row[8:6];
                3'd3:    c = row[11:9];
                3'd4:    c = row[14:12];
                3'd5:    c = row[17:15];
                default: c = 3'd0;
            endcase
            return c;
        end
    endfunction

    // 1.8 fixed point; 256 leaves the color unshaded
    function automatic logic [8:0] shade_factor(input face_t face);
        logic [8:0] f;
        begin
            unique case (face)
                FACE_FRONT, FACE_BACK: f = 9'd205;
                FACE_LEFT, FACE_RIGHT: f = 9'd154;
                FACE_BOTTOM:           f = 9'd102;
                default:               f = 9'd256;
            endcase
            return f;
        end
    endfunction

    function automatic face_t lowest_face(input logic [5:0] faces);
        face_t f;
        begin
            f = FACE_FRONT;
            for (int i = NUM_FACES - 1; i >= 0; i--) begin
                if (faces[i]) begin
                    f = face_t'(3'(i));
                end
            end
            return f;
        end
    endfunction

endpackage
`default_nettype wire

[sv/vfce_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vfce_front
// Input stage: registers each voxel beat, works out its exposed faces and
// drops voxels that emit nothing.
// ----------------------------------------------------------------------------
module vfce_front
    import vfce_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic signed [15:0] s_block_x,
    input  wire logic signed [15:0] s_block_y,
    input  wire logic signed [15:0] s_block_z,
    input  wire logic               s_block_solid,
    input  wire logic [7:0]         s_color_r,
    input  wire logic [7:0]         s_color_g,
    input  wire logic [7:0]         s_color_b,
    input  wire logic [5:0]         s_neighbor_solid_mask,
    input  wire logic               s_valid,
    output logic                    s_ready,
    output logic                    push_valid,
    input  wire logic               push_ready,
    output voxel_t                  push_data
);

    logic   valid_reg;
    voxel_t data_reg;
    logic [5:0] faces;
    logic   take;

    assign faces   = s_block_solid ? ~s_neighbor_solid_mask : 6'd0;
    assign s_ready = !valid_reg || push_ready;
    assign take    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            // hidden or empty voxels never enter the queue
            valid_reg <= take && (faces != 6'd0);
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            data_reg.bx    <= s_block_x;
            data_reg.by    <= s_block_y;
            data_reg.bz    <= s_block_z;
            data_reg.r     <= s_color_r;
            data_reg.g     <= s_color_g;
            data_reg.b     <= s_color_b;
            data_reg.faces <= faces;
        end
    end

    assign push_valid = valid_reg;
    assign push_data  = data_reg;

endmodule
`default_nettype wire

[sv/vfce_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vfce_fifo
// Short voxel queue between the front and back ends.
// ----------------------------------------------------------------------------
module vfce_fifo
    import vfce_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   wr_valid,
    output logic        wr_ready,
    input  wire voxel_t wr_data,
    output logic        rd_valid,
    input  wire logic   rd_ready,
    output voxel_t      rd_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    voxel_t        mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          wr_en;
    logic          rd_en;

    assign wr_ready = (count_reg != CW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign wr_en    = wr_valid && wr_ready;
    assign rd_en    = rd_valid && rd_ready;
    assign rd_data  = mem_reg[rd_ptr_reg];

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (wr_en) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (rd_en) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (wr_en && !rd_en) begin
                count_reg <= count_reg + CW'(1);
            end else if (rd_en && !wr_en) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("queue count over depth");

    a_ptrs_meet_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers apart while empty");

    a_count_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && !rd_en) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("queue count missed a write");

endmodule
`default_nettype wire

[sv/vfce_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vfce_back
// Vertex generator: walks the exposed faces of the head voxel, one vertex
// per cycle while the output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module vfce_back
    import vfce_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               rd_valid,
    output logic                    rd_ready,
    input  wire voxel_t             rd_data,
    output logic signed [16:0]      m_pos_x,
    output logic signed [16:0]      m_pos_y,
    output logic signed [16:0]      m_pos_z,
    output logic [7:0]              m_shade_r,
    output logic [7:0]              m_shade_g,
    output logic [7:0]              m_shade_b,
    output logic [2:0]              m_face_id,
    output logic                    m_last,
    output logic                    m_valid,
    input  wire logic               m_ready
);

    logic       work_valid_reg;
    voxel_t     work_reg;
    logic [5:0] rem_reg;
    logic [2:0] vert_reg;

    logic               m_valid_reg;
    logic signed [16:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic [7:0]         shade_r_reg, shade_g_reg, shade_b_reg;
    face_t              face_reg;
    logic               last_reg;

    face_t       face;
    logic [2:0]  corner;
    logic [8:0]  factor;
    logic [5:0]  rem_clr;
    logic        adv;
    logic        face_done;
    logic        item_done;
    logic        pop;
    logic [16:0] prod_r, prod_g, prod_b;

    assign face      = lowest_face(rem_reg);
    assign corner    = corner_of(face, vert_reg);
    assign factor    = shade_factor(face);
    assign rem_clr   = rem_reg & (rem_reg - 6'd1);
    assign adv       = work_valid_reg && (!m_valid_reg || m_ready);
    assign face_done = (vert_reg == LAST_VERT);
    assign item_done = face_done && (rem_clr == 6'd0);
    assign pop       = rd_valid && (!work_valid_reg || (adv && item_done));
    assign rd_ready  = !work_valid_reg || (adv && item_done);

    assign prod_r = 17'(work_reg.r) * 17'(factor);
    assign prod_g = 17'(work_reg.g) * 17'(factor);
    assign prod_b = 17'(work_reg.b) * 17'(factor);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            work_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            rem_reg        <= '0;
            vert_reg       <= '0;
        end else begin
            if (adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (pop) begin
                work_valid_reg <= 1'b1;
                rem_reg        <= rd_data.faces;
                vert_reg       <= '0;
            end else if (adv) begin
                if (face_done) begin
                    vert_reg <= '0;
                    rem_reg  <= rem_clr;
                    if (item_done) begin
                        work_valid_reg <= 1'b0;
                    end
                end else begin
                    vert_reg <= vert_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            work_reg <= rd_data;
        end
        if (adv) begin
            pos_x_reg   <= {work_reg.bx[15], work_reg.bx} + {16'd0, corner[0]};
            pos_y_reg   <= {work_reg.by[15], work_reg.by} + {16'd0, corner[1]};
            pos_z_reg   <= {work_reg.bz[15], work_reg.bz} + {16'd0, corner[2]};
            shade_r_reg <= prod_r[15:8];
            shade_g_reg <= prod_g[15:8];
            shade_b_reg <= prod_b[15:8];
            face_reg    <= face;
            last_reg    <= item_done;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_pos_x   = pos_x_reg;
    assign m_pos_y   = pos_y_reg;
    assign m_pos_z   = pos_z_reg;
    assign m_shade_r = shade_r_reg;
    assign m_shade_g = shade_g_reg;
    assign m_shade_b = shade_b_reg;
    assign m_face_id = face_reg;
    assign m_last    = last_reg;

    a_work_has_faces: assert property (@(posedge aclk) disable iff (!aresetn)
        work_valid_reg |-> (rem_reg != 6'd0))
        else $error("active voxel with no faces left");

    a_vert_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vert_reg <= LAST_VERT)
        else $error("vertex index out of range");

    a_face_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && !face_done) |=> (face == $past(face)))
        else $error("face changed inside a face");

endmodule
`default_nettype wire

[sv/voxel_face_cull_vertex_emitter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// voxel_face_cull_vertex_emitter
// Culls hidden faces of one voxel per beat and emits six vertices per
// exposed face, shaded per face.
// ----------------------------------------------------------------------------
// A voxel beat is taken by the input stage. A voxel that is not solid or is
// fully enclosed emits nothing and never enters the queue. A voxel with n
// exposed faces gets 6*n vertices (up to 36) from the vertex generator, one
// vertex per cycle through its output register while m_ready does not stall
// it; this generator sets the sustained rate. A queue of FIFO_DEPTH voxels
// lets the input side keep taking beats while vertices drain. A beat reaches
// its first vertex through the input register, the queue, the work register
// and the output register. The last vertex of each voxel has m_last set.
// ----------------------------------------------------------------------------
module voxel_face_cull_vertex_emitter
    import vfce_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic signed [15:0] s_block_x,
    input  wire logic signed [15:0] s_block_y,
    input  wire logic signed [15:0] s_block_z,
    input  wire logic               s_block_solid,
    input  wire logic [7:0]         s_color_r,
    input  wire logic [7:0]         s_color_g,
    input  wire logic [7:0]         s_color_b,
    input  wire logic [5:0]         s_neighbor_solid_mask,
    input  wire logic               s_valid,
    output logic                    s_ready,
    output logic signed [16:0]      m_pos_x,
    output logic signed [16:0]      m_pos_y,
    output logic signed [16:0]      m_pos_z,
    output logic [7:0]              m_shade_r,
    output logic [7:0]              m_shade_g,
    output logic [7:0]              m_shade_b,
    output logic [2:0]              m_face_id,
    output logic                    m_last,
    output logic                    m_valid,
    input  wire logic               m_ready
);

    logic   push_valid;
    logic   push_ready;
    voxel_t push_data;
    logic   rd_valid;
    logic   rd_ready;
    voxel_t rd_data;

    vfce_front u_front (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .s_block_x             (s_block_x),
        .s_block_y             (s_block_y),
        .s_block_z             (s_block_z),
        .s_block_solid         (s_block_solid),
        .s_color_r             (s_color_r),
        .s_color_g             (s_color_g),
        .s_color_b             (s_color_b),
        .s_neighbor_solid_mask (s_neighbor_solid_mask),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .push_valid            (push_valid),
        .push_ready            (push_ready),
        .push_data             (push_data)
    );

    vfce_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_data  (push_data),
        .rd_valid (rd_valid),
        .rd_ready (rd_ready),
        .rd_data  (rd_data)
    );

    vfce_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_valid  (rd_valid),
        .rd_ready  (rd_ready),
        .rd_data   (rd_data),
        .m_pos_x   (m_pos_x),
        .m_pos_y   (m_pos_y),
        .m_pos_z   (m_pos_z),
        .m_shade_r (m_shade_r),
        .m_shade_g (m_shade_g),
        .m_shade_b (m_shade_b),
        .m_face_id (m_face_id),
        .m_last    (m_last),
        .m_valid   (m_valid),
        .m_ready   (m_ready)
    );

endmodule
`default_nettype wire
